// ----- rtl/twa_pkg.sv -----
// Shared types and codes for the time window aggregator.
`default_nettype none
package twa_pkg;

  localparam int TimeW  = 54;
  localparam int LenW   = 53;
  localparam int StartW = 56;
  localparam int ValW   = 32;
  localparam int SumW   = 64;
  localparam int CntW   = 32;
  localparam int WideW  = 58;

  localparam logic [1:0] STAT_WIN   = 2'd0;
  localparam logic [1:0] STAT_ORDER = 2'd1;
  localparam logic [1:0] STAT_OVER  = 2'd2;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_STEP   = 2'd2;
  localparam logic [1:0] REG_OFFSET = 2'd3;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  typedef struct packed {
    logic signed [StartW-1:0] start;
    logic        [CntW-1:0]   count;
    logic signed [SumW-1:0]   sum;
    logic signed [ValW-1:0]   vmin;
    logic signed [ValW-1:0]   vmax;
    logic signed [ValW-1:0]   vfirst;
    logic signed [ValW-1:0]   vlast;
  } win_t;

  typedef struct packed {
    logic shift;
    logic add;
    logic load;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/twa_rem.sv -----
// Restoring remainder unit: one quotient bit per cycle.
`default_nettype none
module twa_rem (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [twa_pkg::TimeW:0]     dividend,
  input  wire logic [twa_pkg::LenW-1:0]    divisor,
  output logic                             done,
  output logic [twa_pkg::LenW-1:0]         rem
);
  localparam int DW = twa_pkg::TimeW + 1;

  logic          busy_r, done_r;
  logic [5:0]    cnt_r;
  logic [DW-1:0] dvd_r;
  logic [twa_pkg::LenW-1:0] dvs_r, rem_r;
  logic [twa_pkg::LenW:0]   trial;

  assign trial = {rem_r, dvd_r[DW-1]};
  assign done  = done_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'(DW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) rem_r <= twa_pkg::LenW'(trial - {1'b0, dvs_r});
      else rem_r <= trial[twa_pkg::LenW-1:0];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/twa_cell.sv -----
// One open window slot of the chain: shift from neighbor, load, or add a value.
`default_nettype none
module twa_cell (
  input  wire logic                        clk,
  input  wire twa_pkg::cell_ctl_t          ctl,
  input  wire twa_pkg::win_t               nbr,
  input  wire twa_pkg::win_t               ins,
  input  wire logic signed [twa_pkg::ValW-1:0] val,
  output twa_pkg::win_t                    win_o
);
  twa_pkg::win_t win_r, added;
  logic signed [twa_pkg::SumW:0] s_ext;

  always_comb begin
    added = win_r;
    s_ext = {win_r.sum[twa_pkg::SumW-1], win_r.sum} + (twa_pkg::SumW+1)'(val);
    if (val < win_r.vmin) added.vmin = val;
    if (val > win_r.vmax) added.vmax = val;
    if (s_ext[twa_pkg::SumW] != s_ext[twa_pkg::SumW-1])
      added.sum = s_ext[twa_pkg::SumW] ? {1'b1, {(twa_pkg::SumW-1){1'b0}}}
                                       : {1'b0, {(twa_pkg::SumW-1){1'b1}}};
    else added.sum = s_ext[twa_pkg::SumW-1:0];
    added.vlast = val;
    if (win_r.count != '1) added.count = win_r.count + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) win_r <= ins;
    else if (ctl.shift) win_r <= nbr;
    else if (ctl.add) win_r <= added;
  end

  assign win_o = win_r;
endmodule
`default_nettype wire

// ----- rtl/time_window_aggregator_core.sv -----
// Top level of the time window aggregator: control, configuration and window chain.
`default_nettype none
// A sample is handled in phases: the remainder of (time - offset) by the window
// step comes from a bit-serial unit, then closing pops one window a cycle from
// the head of the cell chain while the output register can take a result, an add
// step adds the value to every open window, and new windows are walked down and
// up one step per cycle. A flush pops the open windows one at a time. Items are
// handled one at a time; a result waits in the output register while the next
// work goes on.
module time_window_aggregator_core #(
  parameter int MAX_OPEN = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [87:0]  in_tdata,   // sample_time, sample_value, zero pad
  input  wire logic         in_tuser,   // req_type
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [335:0]      out_tdata,  // win_start, win_end, sample_count, value_sum,
                                        // value_min, value_max, value_first, value_last
  output logic [1:0]        out_tuser,  // status
  output logic              out_tlast,  // end_of_run
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [53:0]  cfg_wdata
);
  localparam int UW = $clog2(MAX_OPEN + 1);
  localparam int CW = twa_pkg::LenW + 1 + $clog2(MAX_OPEN + 1);
  localparam int WW = twa_pkg::WideW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STAT  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_CLOSE = 3'd3;
  localparam logic [2:0] ST_ADD   = 3'd4;
  localparam logic [2:0] ST_DOWN  = 3'd5;
  localparam logic [2:0] ST_UP    = 3'd6;
  localparam logic [2:0] ST_FLUSH = 3'd7;

  // configuration
  logic                       mode_r;
  logic [twa_pkg::LenW-1:0]   len_r, step_r;
  logic [twa_pkg::TimeW-1:0]  off_r;
  logic [twa_pkg::LenW-1:0]   len_eff, step_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      len_r  <= twa_pkg::LenW'(1);
      step_r <= twa_pkg::LenW'(1);
      off_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        twa_pkg::REG_MODE:   mode_r <= cfg_wdata[0];
        twa_pkg::REG_LENGTH: len_r  <= cfg_wdata[twa_pkg::LenW-1:0];
        twa_pkg::REG_STEP:   step_r <= cfg_wdata[twa_pkg::LenW-1:0];
        twa_pkg::REG_OFFSET: off_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign len_eff  = (len_r == '0) ? twa_pkg::LenW'(1) : len_r;
  assign step_eff = !mode_r ? len_eff : ((step_r == '0) ? twa_pkg::LenW'(1) : step_r);

  // control state
  logic [2:0]  state_r, state_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic signed [twa_pkg::StartW-1:0] newest_r, newest_nxt;
  logic signed [twa_pkg::TimeW-1:0]  prev_r, prev_nxt, t_r;
  logic        seen_r, seen_nxt;
  logic signed [twa_pkg::ValW-1:0]   v_r;
  logic        neg_r;
  logic signed [WW-1:0] base_r, base_nxt, s_r, s_nxt;
  logic        winok_r, winok_nxt;
  logic [1:0]  code_r, code_nxt;

  // output stage
  logic          out_valid_r;
  twa_pkg::win_t out_win_r;
  logic [1:0]    out_stat_r;
  logic          out_last_r;
  logic          can_push, push, push_last;
  logic [1:0]    push_stat;
  logic          push_zero;

  // chain
  twa_pkg::win_t     win_q [MAX_OPEN+1];
  twa_pkg::win_t     ins_w;
  logic do_pop, do_add, do_load;

  // input fields
  logic signed [twa_pkg::TimeW-1:0] in_time;
  logic signed [twa_pkg::ValW-1:0]  in_val;
  logic signed [twa_pkg::TimeW:0]   diff;
  logic [twa_pkg::TimeW:0]          mag;
  logic accept, div_start, div_done;
  logic [twa_pkg::LenW-1:0] div_rem, r_w;

  assign in_time = in_tdata[53:0];
  assign in_val  = in_tdata[85:54];
  assign diff    = {in_time[twa_pkg::TimeW-1], in_time} - {off_r[twa_pkg::TimeW-1], off_r};
  assign mag     = diff[twa_pkg::TimeW] ? (twa_pkg::TimeW+1)'(-diff) : diff;
  assign in_tready = (state_r == ST_IDLE);
  assign accept  = in_tvalid && in_tready;
  assign div_start = accept && (in_tuser == twa_pkg::REQ_SAMPLE) &&
                     !(seen_r && (in_time < prev_r));

  twa_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .divisor  (step_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign r_w = (neg_r && div_rem != '0) ? twa_pkg::LenW'(step_eff - div_rem) : div_rem;

  // window end at or before the sample time
  function automatic logic closes(input logic signed [twa_pkg::StartW-1:0] st,
                                  input logic [twa_pkg::LenW-1:0] ln,
                                  input logic signed [twa_pkg::TimeW-1:0] t);
    logic signed [WW-1:0] e;
    begin
      e = WW'(st) + $signed({{(WW-twa_pkg::LenW){1'b0}}, ln});
      closes = e <= WW'(t);
    end
  endfunction

  logic head_closes, next_closes;
  logic signed [WW-1:0] t_wide, low_lim, s_dn, s_up;
  logic [CW-1:0] span;

  assign head_closes = closes(win_q[0].start, len_eff, t_r);
  assign next_closes = closes(win_q[1].start, len_eff, t_r);
  assign t_wide  = WW'(t_r);
  assign low_lim = t_wide - WW'(len_eff);
  assign s_dn    = s_r - WW'(step_eff);
  assign s_up    = s_r + WW'(step_eff);
  assign span    = CW'(r_w) + CW'(step_eff) * CW'(MAX_OPEN);
  assign can_push = !out_valid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    used_nxt   = used_r;
    newest_nxt = newest_r;
    prev_nxt   = prev_r;
    seen_nxt   = seen_r;
    base_nxt   = base_r;
    s_nxt      = s_r;
    winok_nxt  = winok_r;
    code_nxt   = code_r;
    push = 1'b0; push_last = 1'b0; push_stat = twa_pkg::STAT_WIN; push_zero = 1'b0;
    do_pop = 1'b0; do_add = 1'b0; do_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == twa_pkg::REQ_FLUSH) begin
            if (used_r != '0) state_nxt = ST_FLUSH;
          end else if (seen_r && (in_time < prev_r)) begin
            code_nxt  = twa_pkg::STAT_ORDER;
            state_nxt = ST_STAT;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_STAT: begin
        if (can_push) begin
          push = 1'b1; push_last = 1'b1; push_stat = code_r; push_zero = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (span < CW'(len_eff)) begin
            code_nxt  = twa_pkg::STAT_OVER;
            state_nxt = ST_STAT;
          end else begin
            prev_nxt  = t_r;
            seen_nxt  = 1'b1;
            base_nxt  = t_wide - WW'(r_w);
            s_nxt     = t_wide - WW'(r_w);
            winok_nxt = r_w < len_eff;
            state_nxt = ST_CLOSE;
          end
        end
      end
      ST_CLOSE: begin
        if (used_r != '0 && head_closes) begin
          if (can_push) begin
            push = 1'b1;
            push_last = (used_r == UW'(1)) || !next_closes;
            do_pop = 1'b1;
            used_nxt = used_r - UW'(1);
          end
        end else begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        do_add = 1'b1;
        state_nxt = winok_r ? ST_DOWN : ST_IDLE;
      end
      ST_DOWN: begin
        // walk to the oldest window holding the sample
        if (s_dn > low_lim) s_nxt = s_dn;
        else state_nxt = ST_UP;
      end
      ST_UP: begin
        if (s_r > base_r) begin
          state_nxt = ST_IDLE;
        end else begin
          if (used_r < UW'(MAX_OPEN) &&
              (used_r == '0 || s_r > WW'(newest_r))) begin
            do_load    = 1'b1;
            used_nxt   = used_r + UW'(1);
            newest_nxt = s_r[twa_pkg::StartW-1:0];
          end
          s_nxt = s_up;
        end
      end
      ST_FLUSH: begin
        if (can_push) begin
          push = 1'b1;
          push_last = (used_r == UW'(1));
          do_pop = 1'b1;
          used_nxt = used_r - UW'(1);
          if (used_r == UW'(1)) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      prev_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      prev_r  <= prev_nxt;
      seen_r  <= seen_nxt;
      if (push) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    newest_r <= newest_nxt;
    base_r   <= base_nxt;
    s_r      <= s_nxt;
    winok_r  <= winok_nxt;
    code_r   <= code_nxt;
    if (accept) begin
      t_r   <= in_time;
      v_r   <= in_val;
      neg_r <= diff[twa_pkg::TimeW];
    end
    if (push) begin
      out_win_r  <= push_zero ? '0 : win_q[0];
      out_stat_r <= push_stat;
      out_last_r <= push_last;
    end
  end

  always_comb begin
    ins_w        = '0;
    ins_w.start  = s_r[twa_pkg::StartW-1:0];
    ins_w.count  = twa_pkg::CntW'(1);
    ins_w.sum    = twa_pkg::SumW'(v_r);
    ins_w.vmin   = v_r;
    ins_w.vmax   = v_r;
    ins_w.vfirst = v_r;
    ins_w.vlast  = v_r;
  end

  assign win_q[MAX_OPEN] = '0;

  for (genvar i = 0; i < MAX_OPEN; i++) begin : g_cell
    twa_pkg::cell_ctl_t ctl;
    assign ctl.shift = do_pop;
    assign ctl.add   = do_add && (UW'(i) < used_r);
    assign ctl.load  = do_load && (UW'(i) == used_r);
    twa_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .nbr   (win_q[i+1]),
      .ins   (ins_w),
      .val   (v_r),
      .win_o (win_q[i])
    );
  end

  // status records carry a zero window; a real record has count of at least one
  function automatic logic signed [twa_pkg::StartW-1:0] push_zero_r_free(
      input logic signed [twa_pkg::StartW-1:0] st,
      input logic [twa_pkg::CntW-1:0] cnt,
      input logic [twa_pkg::LenW-1:0] ln);
    begin
      if (cnt == '0) push_zero_r_free = '0;
      else push_zero_r_free = st + twa_pkg::StartW'((ln == '0) ? twa_pkg::LenW'(1) : ln);
    end
  endfunction

  logic signed [twa_pkg::StartW-1:0] out_end;
  assign out_end = push_zero_r_free(out_win_r.start, out_win_r.count, len_r);

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_win_r.vlast, out_win_r.vfirst, out_win_r.vmax, out_win_r.vmin,
                       out_win_r.sum, out_win_r.count, out_end, out_win_r.start};

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(MAX_OPEN))
    else $error("open window count beyond capacity");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != twa_pkg::STAT_WIN |-> out_tlast)
    else $error("status result without end of run");

  a_empty_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == twa_pkg::REQ_FLUSH && used_r == '0 |=> in_tready)
    else $error("empty flush stalled the input");
endmodule
`default_nettype wire

// ----- tb/time_window_aggregator_core_tb.sv -----
// Self-checking testbench for the time window aggregator core.
`default_nettype none
module time_window_aggregator_core_tb;

  localparam int NWIN = 8;
  localparam int SETTLE = 200;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam longint TMAX = 64'sd9007199254740991;
  localparam longint TMIN = -64'sd9007199254740991;
  localparam longint SUM_HI = 64'sh7fffffffffffffff;
  localparam longint SUM_LO = 64'sh8000000000000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [55:0] wstart;
    logic [55:0] wend;
    logic [31:0] cnt;
    logic [63:0] sum;
    logic [31:0] vmin;
    logic [31:0] vmax;
    logic [31:0] vfirst;
    logic [31:0] vlast;
    logic        eor;
  } rec_t;

  typedef enum {ROW_ITEM, ROW_FLUSH, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [1:0] addr;
    logic [53:0] data;
    longint     t;
    int         v;
    bit         typed;
    logic [1:0] status;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [87:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [335:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = '0;
  logic [53:0]  cfg_wdata = '0;

  time_window_aggregator_core #(.MAX_OPEN(NWIN)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of configuration and window state
  bit          m_mode;
  longint      m_len = 1;
  longint      m_step = 1;
  longint      m_off;
  longint      w_start [NWIN];
  logic [31:0] w_cnt [NWIN];
  longint      w_sum [NWIN];
  int          w_min [NWIN];
  int          w_max [NWIN];
  int          w_first [NWIN];
  int          w_last [NWIN];
  int          w_used;
  longint      prev_t;
  bit          seen_any;

  rec_t window_q[$];
  int   errors;
  int   n_items, n_windows, n_status;
  bit   quiet;
  bit   hold_req;
  int   stall_cycles;
  rec_t got;
  rec_t want;

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic rec_t status_rec(logic [1:0] code);
    rec_t r;
    r = '0;
    r.status = code;
    r.eor = 1'b1;
    return r;
  endfunction

  function automatic rec_t window_rec(int i, longint lenv, bit eor);
    rec_t r;
    longint e;
    e = w_start[i] + lenv;
    r.status = twa_pkg::STAT_WIN;
    r.wstart = w_start[i][55:0];
    r.wend = e[55:0];
    r.cnt = w_cnt[i];
    r.sum = w_sum[i];
    r.vmin = w_min[i];
    r.vmax = w_max[i];
    r.vfirst = w_first[i];
    r.vlast = w_last[i];
    r.eor = eor;
    return r;
  endfunction

  // Work out the results of one accepted beat and update the window state.
  task automatic aggregate_beat(bit flush, longint t, int v);
    longint lenv, stepv, kmin, kmax, k, s;
    int i, keep, last_close;
    lenv = (m_len == 0) ? 1 : m_len;
    stepv = (m_step == 0) ? 1 : m_step;
    if (!m_mode) stepv = lenv;
    if (flush) begin
      for (i = 0; i < w_used; i++) window_q.push_back(window_rec(i, lenv, i == w_used - 1));
      w_used = 0;
      return;
    end
    if (seen_any && t < prev_t) begin
      window_q.push_back(status_rec(twa_pkg::STAT_ORDER));
      return;
    end
    kmin = floor_div(t - m_off - lenv, stepv) + 1;
    kmax = floor_div(t - m_off, stepv);
    if (kmax >= kmin && kmax - kmin + 1 > NWIN) begin
      window_q.push_back(status_rec(twa_pkg::STAT_OVER));
      return;
    end
    prev_t = t;
    seen_any = 1'b1;
    last_close = -1;
    for (i = 0; i < w_used; i++) if (w_start[i] + lenv <= t) last_close = i;
    keep = 0;
    for (i = 0; i < w_used; i++) begin
      if (w_start[i] + lenv <= t) begin
        window_q.push_back(window_rec(i, lenv, i == last_close));
      end else begin
        w_start[keep] = w_start[i];
        w_cnt[keep] = w_cnt[i];
        w_sum[keep] = w_sum[i];
        w_min[keep] = w_min[i];
        w_max[keep] = w_max[i];
        w_first[keep] = w_first[i];
        w_last[keep] = w_last[i];
        keep++;
      end
    end
    w_used = keep;
    for (k = kmin; k <= kmax; k++) begin
      s = m_off + k * stepv;
      if (w_used >= NWIN) break;
      if (w_used > 0 && s <= w_start[w_used - 1]) continue;
      w_start[w_used] = s;
      w_cnt[w_used] = '0;
      w_sum[w_used] = 0;
      w_min[w_used] = v;
      w_max[w_used] = v;
      w_first[w_used] = v;
      w_last[w_used] = v;
      w_used++;
    end
    for (i = 0; i < w_used; i++) begin
      if (v < w_min[i]) w_min[i] = v;
      if (v > w_max[i]) w_max[i] = v;
      if (v > 0 && w_sum[i] > SUM_HI - v) w_sum[i] = SUM_HI;
      else if (v < 0 && w_sum[i] < SUM_LO - v) w_sum[i] = SUM_LO;
      else w_sum[i] += v;
      w_last[i] = v;
      if (w_cnt[i] != 32'hffffffff) w_cnt[i]++;
    end
  endtask

  task automatic report_mismatch(string field, logic [63:0] seen, logic [63:0] exp_v);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", field, seen, exp_v, $realtime);
  endtask

  // Offer one beat; with typed set, the given status stands in for the predictor.
  task automatic send_beat(bit flush, longint t, int v, bit typed, logic [1:0] code);
    logic [53:0] tf;
    tf = t[53:0];
    in_tvalid <= 1'b1;
    in_tuser <= flush ? twa_pkg::REQ_FLUSH : twa_pkg::REQ_SAMPLE;
    in_tdata <= {2'b00, v, tf};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_items++;
    if (typed) window_q.push_back(status_rec(code));
    else aggregate_beat(flush, t, v);
  endtask

  task automatic pause(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop valid, wait out every result and the tail of any silent item.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (window_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [53:0] d);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    case (idx)
      twa_pkg::REG_MODE:   m_mode = d[0];
      twa_pkg::REG_LENGTH: m_len = longint'(d[52:0]);
      twa_pkg::REG_STEP:   m_step = longint'(d[52:0]);
      default:             m_off = longint'(signed'(d));
    endcase
  endtask

  task automatic end_cfg();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random back-pressure, one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checker and stall watchdog
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.wstart = out_tdata[55:0];
      got.wend = out_tdata[111:56];
      got.cnt = out_tdata[143:112];
      got.sum = out_tdata[207:144];
      got.vmin = out_tdata[239:208];
      got.vmax = out_tdata[271:240];
      got.vfirst = out_tdata[303:272];
      got.vlast = out_tdata[335:304];
      got.eor = out_tlast;
      if (window_q.size() == 0) begin
        report_mismatch("unexpected beat, status", 64'(got.status), 64'd0);
      end else begin
        want = window_q.pop_front();
        if (want.status == twa_pkg::STAT_WIN) n_windows++;
        else n_status++;
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.wstart !== want.wstart) report_mismatch("win_start", got.wstart, want.wstart);
        if (got.wend !== want.wend) report_mismatch("win_end", got.wend, want.wend);
        if (got.cnt !== want.cnt) report_mismatch("sample_count", got.cnt, want.cnt);
        if (got.sum !== want.sum) report_mismatch("value_sum", got.sum, want.sum);
        if (got.vmin !== want.vmin) report_mismatch("value_min", got.vmin, want.vmin);
        if (got.vmax !== want.vmax) report_mismatch("value_max", got.vmax, want.vmax);
        if (got.vfirst !== want.vfirst) report_mismatch("value_first", got.vfirst, want.vfirst);
        if (got.vlast !== want.vlast) report_mismatch("value_last", got.vlast, want.vlast);
        if (got.eor !== want.eor) report_mismatch("end_of_run", got.eor, want.eor);
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else if (in_tvalid || window_q.size() != 0) stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("[time_window_aggregator_core] ERROR");
      $finish;
    end
  end

  row_t rows[23];

  initial begin
    int ph, j, pick;
    longint t, lenr, stepr;
    rows = '{
      '{ROW_ITEM, 2'd0, 54'd0, TMIN, 32'h7fffffff, 0, twa_pkg::STAT_WIN},
      '{ROW_ITEM, 2'd0, 54'd0, 0, 32'h80000000, 0, twa_pkg::STAT_WIN},
      '{ROW_ITEM, 2'd0, 54'd0, -5, 1, 1, twa_pkg::STAT_ORDER},
      '{ROW_ITEM, 2'd0, 54'd0, 3, 2, 0, twa_pkg::STAT_WIN},
      '{ROW_FLUSH, 2'd0, 54'd0, 0, 0, 0, twa_pkg::STAT_WIN},
      '{ROW_FLUSH, 2'd0, 54'd0, 0, 0, 0, twa_pkg::STAT_WIN},
      '{ROW_CFG, twa_pkg::REG_MODE, 54'd1, 0, 0, 0, twa_pkg::STAT_WIN},
      '{ROW_CFG, twa_pkg::REG_LENGTH, 54'd100, 0, 0, 0, twa_pkg::STAT_WIN},
      '{ROW_CFG, twa_pkg::REG_STEP, 54'd1, 0, 0, 0, twa_pkg::STAT_WIN},
      '{ROW_ITEM, 2'd0, 54'd0, 50, 4, 1, twa_pkg::STAT_OVER},
      '{ROW_CFG, twa_pkg::REG_LENGTH, 54'd0, 0, 0, 0, twa_pkg::STAT_WIN},
      '{ROW_CFG, twa_pkg::REG_STEP, 54'd0, 0, 0, 0, twa_pkg::STAT_WIN},
      '{ROW_ITEM, 2'd0, 54'd0, 60, -7, 0, twa_pkg::STAT_WIN},
      '{ROW_CFG, twa_pkg::REG_LENGTH, 54'd8, 0, 0, 0, twa_pkg::STAT_WIN},
      '{ROW_CFG, twa_pkg::REG_OFFSET, 54'h3ffffffffffffd, 0, 0, 0, twa_pkg::STAT_WIN},
      '{ROW_ITEM, 2'd0, 54'd0, 70, 100, 0, twa_pkg::STAT_WIN},
      '{ROW_ITEM, 2'd0, 54'd0, 71, -100, 0, twa_pkg::STAT_WIN},
      '{ROW_CFG, twa_pkg::REG_STEP, 54'd20, 0, 0, 0, twa_pkg::STAT_WIN},
      '{ROW_CFG, twa_pkg::REG_LENGTH, 54'd5, 0, 0, 0, twa_pkg::STAT_WIN},
      '{ROW_ITEM, 2'd0, 54'd0, 90, 9, 0, twa_pkg::STAT_WIN},
      '{ROW_FLUSH, 2'd0, 54'd0, 0, 0, 0, twa_pkg::STAT_WIN},
      '{ROW_CFG, twa_pkg::REG_MODE, 54'd0, 0, 0, 0, twa_pkg::STAT_WIN},
      '{ROW_ITEM, 2'd0, 54'd0, 95, 0, 0, twa_pkg::STAT_WIN}
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (rows[r]) begin
      case (rows[r].kind)
        ROW_CFG: begin
          drain();
          write_reg(rows[r].addr, rows[r].data);
          end_cfg();
        end
        ROW_FLUSH: send_beat(1'b1, 0, 0, 1'b0, twa_pkg::STAT_WIN);
        default: send_beat(1'b0, rows[r].t, rows[r].v, rows[r].typed, rows[r].status);
      endcase
      if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 16));
    end

    for (ph = 0; ph < 8; ph++) begin
      drain();
      lenr = $urandom_range(1, 24);
      stepr = $urandom_range(1, 12);
      if (ph % 3 == 1) lenr = stepr * $urandom_range(7, 10);
      write_reg(twa_pkg::REG_MODE, 54'($urandom_range(0, 1)));
      write_reg(twa_pkg::REG_LENGTH, 54'(lenr));
      write_reg(twa_pkg::REG_STEP, 54'(stepr));
      if (ph == 2) write_reg(twa_pkg::REG_OFFSET, 54'(-TMAX));
      else write_reg(twa_pkg::REG_OFFSET, 54'(longint'($urandom_range(0, 200)) - 100));
      end_cfg();
      quiet = (ph == 7);
      if (ph == 3) hold_req = 1'b1;
      for (j = 0; j < 32; j++) begin
        if (!quiet && $urandom_range(0, 3) == 0) pause($urandom_range(1, 16));
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          send_beat(1'b1, 0, $urandom, 1'b0, twa_pkg::STAT_WIN);
        end else begin
          if (pick < 14) t = prev_t - $urandom_range(1, 50);
          else t = prev_t + $urandom_range(0, 2 * (lenr + stepr));
          send_beat(1'b0, t, $urandom, 1'b0, twa_pkg::STAT_WIN);
        end
      end
    end

    // widest window, largest step and top of the time range last
    drain();
    write_reg(twa_pkg::REG_MODE, 54'd1);
    write_reg(twa_pkg::REG_STEP, 54'(TMAX));
    write_reg(twa_pkg::REG_LENGTH, 54'(TMAX));
    write_reg(twa_pkg::REG_OFFSET, 54'(TMAX));
    end_cfg();
    send_beat(1'b0, TMAX, $urandom, 1'b0, twa_pkg::STAT_WIN);
    send_beat(1'b0, TMAX, 32'h80000000, 1'b0, twa_pkg::STAT_WIN);
    send_beat(1'b1, 0, 0, 1'b0, twa_pkg::STAT_WIN);
    drain();

    $display("covered %0d input beats over directed cases and 8 random settings", n_items);
    $display("checked %0d window records and %0d status beats", n_windows, n_status);
    if (errors == 0) begin
      $display("[time_window_aggregator_core] OK");
    end else begin
      $display("[time_window_aggregator_core] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
